### hw/rtl/hcc_pkg.sv
// Shared types, constants and key function of the histogram collision counter.
`timescale 1ns / 1ps
`default_nettype none

package hcc_pkg;

   localparam int CELLS_W = 64;
   localparam int KEY_W   = 16;
   localparam int COUNT_W = 21;
   localparam int TOTAL_W = 39;
   localparam int EPOCH_W = 4;
   localparam int ADDR_W  = 2;
   localparam int DATA_W  = 32;
   localparam int OFFS_W  = 2;

   // Byte address of the column offset register.
   localparam logic [ADDR_W-1:0] REG_COLUMN_OFFSET = 2'd0;

   localparam longint unsigned MAX_SET_ITEMS   = 64'd1048576;
   localparam longint unsigned COUNT_FIELD_MAX = 64'd2097151;
   localparam longint unsigned TOTAL_FIELD_MAX = 64'd549755813887;
   localparam longint unsigned SET_PAIRS       = (MAX_SET_ITEMS * (MAX_SET_ITEMS - 64'd1)) / 64'd2;

   // A key counter never exceeds the largest possible set.
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (MAX_SET_ITEMS < COUNT_FIELD_MAX) ? COUNT_W'(MAX_SET_ITEMS) : COUNT_W'(COUNT_FIELD_MAX);

   // The total never exceeds the pair count of the largest possible set.
   localparam logic [TOTAL_W-1:0] TOTAL_CAP =
      (MAX_SET_ITEMS < 64'd2)        ? '0 :
      (MAX_SET_ITEMS > 64'd16777216) ? TOTAL_W'(TOTAL_FIELD_MAX) :
      (SET_PAIRS < TOTAL_FIELD_MAX)  ? TOTAL_W'(SET_PAIRS) : TOTAL_W'(TOTAL_FIELD_MAX);

   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [COUNT_W-1:0] count;
   } hcc_entry_type;

   typedef struct packed {
      logic               en;
      logic [KEY_W-1:0]   key;
      hcc_entry_type      entry;
   } hcc_wr_type;

   // Key nibble j is the cell at row j, column (offset - j) mod 4.
   function automatic logic [KEY_W-1:0] form_key(input logic [CELLS_W-1:0] cells,
                                                 input logic [OFFS_W-1:0]  offset);
      logic [KEY_W-1:0] key;
      logic [1:0]       col;
      logic [3:0]       cell_idx;
      key = '0;
      for (int j = 0; j < 4; j++) begin
         col      = 2'(offset - 2'(j));
         cell_idx = {col, 2'(j)};
         key[4*j +: 4] = cells[4*cell_idx +: 4];
      end
      return key;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/histogram_collision_counter_unit.sv
// Top level of the histogram collision counter.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Beat contents
// req       in         req_valid / req_stall   ciphertext_nibbles, last_item
// rsp       out        rsp_valid / rsp_stall   collision_total, total_is_odd
// csr       in/out     psel, penable, pready   column_offset at byte address 0
//
// One beat is accepted per cycle while req_stall is low. The key is formed and the
// counter memory is read in the cycle of acceptance; the update stage then updates
// the count that was read and writes it back, with the previous write forwarded
// when the keys match. A result beat is loaded into the output register when its
// last item leaves the update stage. After reset, and after every sixteenth set
// (when the set tag wraps), the memory is swept clear while req_stall is held high.
// A result waiting under rsp_stall stalls only a last item, and the items behind it.

module histogram_collision_counter_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Input channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [hcc_pkg::CELLS_W-1:0]    req_ciphertext_nibbles,
   input  wire logic                           req_last_item,
   // Result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [hcc_pkg::TOTAL_W-1:0]         rsp_collision_total,
   output logic                                rsp_total_is_odd,
   // Configuration port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [hcc_pkg::ADDR_W-1:0]     paddr,
   input  wire logic [hcc_pkg::DATA_W-1:0]     pwdata,
   output logic [hcc_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);

   // Configuration register.
   logic [hcc_pkg::OFFS_W-1:0] offset_ff;

   // Update stage: one item whose counter read is in flight.
   logic                          s1_vld_ff;
   logic [hcc_pkg::KEY_W-1:0]     s1_key_ff;
   logic                          s1_last_ff;

   // Last write, kept for forwarding to the item right behind it.
   logic                          fwd_vld_ff;
   logic [hcc_pkg::KEY_W-1:0]     wr_key_ff;
   logic [hcc_pkg::COUNT_W-1:0]   wr_cnt_ff;

   // Set state.
   logic [hcc_pkg::EPOCH_W-1:0]   epoch_ff;
   logic [hcc_pkg::TOTAL_W-1:0]   total_ff;
   logic [hcc_pkg::TOTAL_W-1:0]   total_in;

   // Output register.
   logic                          out_vld_ff;
   logic [hcc_pkg::TOTAL_W-1:0]   out_total_ff;

   logic                          accept;
   logic                          s1_go;
   logic                          wrap_hold;
   logic                          sweeping;
   logic [hcc_pkg::KEY_W-1:0]     rd_key;
   hcc_pkg::hcc_entry_type        rd_entry;
   hcc_pkg::hcc_wr_type           wr;
   logic [hcc_pkg::COUNT_W-1:0]   prev_raw;
   logic [hcc_pkg::COUNT_W-1:0]   prev;
   logic [hcc_pkg::COUNT_W-1:0]   cnt_in;
   logic [hcc_pkg::TOTAL_W:0]     sum;

   // ---------------------------------------------------------------------
   // Configuration port: writes land on the access cycle, reads return the value.
   // ---------------------------------------------------------------------
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (psel && penable && pwrite && pready &&
                   paddr == hcc_pkg::REG_COLUMN_OFFSET) begin
         offset_ff <= pwdata[hcc_pkg::OFFS_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == hcc_pkg::REG_COLUMN_OFFSET) begin
         prdata[hcc_pkg::OFFS_W-1:0] = offset_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Flow control. The update stage holds a last item while the output
   // register is still full and stalled. A last item that wraps the set tag
   // keeps new items out so that none reads across the coming sweep.
   // ---------------------------------------------------------------------
   assign s1_go     = s1_vld_ff && !(s1_last_ff && out_vld_ff && rsp_stall);
   assign wrap_hold = s1_vld_ff && s1_last_ff && (epoch_ff == hcc_pkg::EPOCH_MAX);
   assign req_stall = sweeping || (s1_vld_ff && !s1_go) || wrap_hold;
   assign accept    = req_valid && !req_stall;

   assign rd_key = hcc_pkg::form_key(req_ciphertext_nibbles, offset_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_go) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_key_ff  <= rd_key;
         s1_last_ff <= req_last_item;
      end
   end

   // ---------------------------------------------------------------------
   // Count update. An entry tagged with an older set reads as zero. The
   // previous write is forwarded since the memory read beside it saw old data.
   // ---------------------------------------------------------------------
   always_comb begin
      if (fwd_vld_ff && wr_key_ff == s1_key_ff) begin
         prev_raw = wr_cnt_ff;
      end else if (rd_entry.epoch == epoch_ff) begin
         prev_raw = rd_entry.count;
      end else begin
         prev_raw = '0;
      end
      prev   = (prev_raw > hcc_pkg::COUNT_CAP) ? hcc_pkg::COUNT_CAP : prev_raw;
      cnt_in = (prev < hcc_pkg::COUNT_CAP) ? prev + 1'b1 : hcc_pkg::COUNT_CAP;

      // The total gains the earlier count of the key and saturates at its cap.
      sum = {1'b0, total_ff} + (hcc_pkg::TOTAL_W + 1)'(prev);
      if (sum > {1'b0, hcc_pkg::TOTAL_CAP}) begin
         total_in = hcc_pkg::TOTAL_CAP;
      end else begin
         total_in = sum[hcc_pkg::TOTAL_W-1:0];
      end
   end

   always_comb begin
      wr             = '0;
      wr.en          = s1_go;
      wr.key         = s1_key_ff;
      wr.entry.epoch = epoch_ff;
      wr.entry.count = cnt_in;
   end

   hcc_count_store u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_key      (rd_key),
      .rd_entry    (rd_entry),
      .wr          (wr),
      .sweep_start (s1_go && wrap_hold),
      .sweeping    (sweeping)
   );

   // A last item closes the set: new tag, zero total, no forwarding across it.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
         epoch_ff   <= '0;
         total_ff   <= '0;
      end else if (s1_go) begin
         if (s1_last_ff) begin
            fwd_vld_ff <= 1'b0;
            epoch_ff   <= epoch_ff + 1'b1;
            total_ff   <= '0;
         end else begin
            fwd_vld_ff <= 1'b1;
            total_ff   <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         wr_key_ff <= s1_key_ff;
         wr_cnt_ff <= cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (s1_go && s1_last_ff) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         out_total_ff <= total_in;
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_collision_total = out_total_ff;
   assign rsp_total_is_odd    = out_total_ff[0];

endmodule

`default_nettype wire

### hw/rtl/hcc_count_store.sv
// Key counter memory with epoch tags and a clearing sweep.
`timescale 1ns / 1ps
`default_nettype none

module hcc_count_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [hcc_pkg::KEY_W-1:0]     rd_key,
   output hcc_pkg::hcc_entry_type             rd_entry,
   input  wire hcc_pkg::hcc_wr_type           wr,
   input  wire logic                          sweep_start,
   output logic                               sweeping
);

   localparam int Depth = 1 << hcc_pkg::KEY_W;

   hcc_pkg::hcc_entry_type count_mem [Depth];
   hcc_pkg::hcc_entry_type rd_entry_ff;

   logic                       sweep_ff;
   logic                       sweep_in;
   logic [hcc_pkg::KEY_W-1:0]  sweep_addr_ff;
   logic [hcc_pkg::KEY_W-1:0]  sweep_addr_in;

   // The sweep zeroes one entry a cycle; item writes never overlap it.
   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         count_mem[sweep_addr_ff] <= '0;
      end else if (wr.en) begin
         count_mem[wr.key] <= wr.entry;
      end
      if (rd_en) begin
         rd_entry_ff <= count_mem[rd_key];
      end
   end

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (&sweep_addr_ff) begin
            sweep_in = 1'b0;
         end
      end else if (sweep_start) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign sweeping = sweep_ff;

endmodule

`default_nettype wire
